// ===== src/ohlc_period_bar_aggregator_defines.svh =====
`ifndef OHLC_PERIOD_BAR_AGGREGATOR_DEFINES_SVH
`define OHLC_PERIOD_BAR_AGGREGATOR_DEFINES_SVH

// same-cycle implication
`define OPBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define OPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== src/opba_pkg.sv =====
package opba_pkg;

	localparam int PRICE_W = 40;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int MODE_W  = 2;
	localparam int KEY_W   = 23;
	localparam int PUSH_W  = 2;

	localparam int N_PX     = 4;
	localparam int PX_OPEN  = 0;
	localparam int PX_HIGH  = 1;
	localparam int PX_LOW   = 2;
	localparam int PX_CLOSE = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_WEEKLY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MONTHLY = 2'd2;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} q_stat_t;

endpackage

// ===== src/ohlc_period_bar_aggregator.sv =====
// Results: a request taken pushes up to two results into the four-entry result queue,
// which absorbs both; the second follows the first on out_valid.
// Throughput: one request per cycle while in_stall is low, set by the seven-stage
// date/key pipeline feeding the group merge stage.
// Reset (arst_n low, asynchronous): pipeline empty, queue empty, no group open, daily mode.
`include "ohlc_period_bar_aggregator_defines.svh"

module ohlc_period_bar_aggregator
	import opba_pkg::*;
#(
	parameter int PRICE_WIDTH = PRICE_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [MODE_W-1:0]       cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [YEAR_W-1:0]       year,
	input  logic [MONTH_W-1:0]      month,
	input  logic [DAY_W-1:0]        day,
	input  logic [PRICE_WIDTH-1:0]  open_price,
	input  logic [PRICE_WIDTH-1:0]  high_price,
	input  logic [PRICE_WIDTH-1:0]  low_price,
	input  logic [PRICE_WIDTH-1:0]  close_price,
	input  logic                    final_bar,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [YEAR_W-1:0]       bar_year,
	output logic [MONTH_W-1:0]      bar_month,
	output logic [DAY_W-1:0]        bar_day,
	output logic [PRICE_WIDTH-1:0]  bar_open,
	output logic [PRICE_WIDTH-1:0]  bar_high,
	output logic [PRICE_WIDTH-1:0]  bar_low,
	output logic [PRICE_WIDTH-1:0]  bar_close,
	output logic                    run_end
);

	logic [MODE_W-1:0] mode_q;

	date_t                             in_date;
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  in_px;

	logic                              v_s7, fin_s7;
	date_t                             date_s7;
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  px_s7;
	logic [KEY_W-1:0]                  key_s7;

	logic                              en, fire, grp_open;
	logic [PUSH_W-1:0]                 push_n;
	date_t                             a_date, b_date, head_date;
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  a_px, b_px, head_px;
	logic                              a_end, b_end;
	q_stat_t                           q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_comb begin
		in_date.year     = year;
		in_date.month    = month;
		in_date.day      = day;
		in_px[PX_OPEN]   = open_price;
		in_px[PX_HIGH]   = high_price;
		in_px[PX_LOW]    = low_price;
		in_px[PX_CLOSE]  = close_price;
	end

	assign fire     = v_s7 && q_stat.room;
	assign en       = !v_s7 || q_stat.room;
	assign in_stall = !en;

	opba_key_pipe #(
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_key_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.mode      (mode_q),
		.bar_valid (in_valid),
		.bar_date  (in_date),
		.bar_px    (in_px),
		.bar_fin   (final_bar),
		.valid_s7  (v_s7),
		.date_s7   (date_s7),
		.px_s7     (px_s7),
		.fin_s7    (fin_s7),
		.key_s7    (key_s7)
	);

	opba_merge #(
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.mode     (mode_q),
		.date     (date_s7),
		.px       (px_s7),
		.fin      (fin_s7),
		.key      (key_s7),
		.push_n   (push_n),
		.a_date   (a_date),
		.a_px     (a_px),
		.a_end    (a_end),
		.b_date   (b_date),
		.b_px     (b_px),
		.b_end    (b_end),
		.grp_open (grp_open)
	);

	opba_out_queue #(
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.a_date    (a_date),
		.a_px      (a_px),
		.a_end     (a_end),
		.b_date    (b_date),
		.b_px      (b_px),
		.b_end     (b_end),
		.stall     (out_stall),
		.valid     (out_valid),
		.head_date (head_date),
		.head_px   (head_px),
		.head_end  (run_end),
		.stat      (q_stat)
	);

	assign bar_year  = head_date.year;
	assign bar_month = head_date.month;
	assign bar_day   = head_date.day;
	assign bar_open  = head_px[PX_OPEN];
	assign bar_high  = head_px[PX_HIGH];
	assign bar_low   = head_px[PX_LOW];
	assign bar_close = head_px[PX_CLOSE];

	`OPBA_ASSERT_NOW(a_stall_has_result, clk, arst_n, in_stall, out_valid)
	`OPBA_ASSERT_NEXT(a_final_closes_group, clk, arst_n, fire && fin_s7, !grp_open)
	`OPBA_ASSERT_NOW(a_queue_bound, clk, arst_n, push_n != PUSH_W'(0), q_stat.room)

endmodule

// ===== src/opba_key_pipe.sv =====
module opba_key_pipe
	import opba_pkg::*;
#(
	parameter int PRICE_WIDTH = PRICE_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [MODE_W-1:0]                 mode,
	input  logic                              bar_valid,
	input  date_t                             bar_date,
	input  logic [N_PX-1:0][PRICE_WIDTH-1:0]  bar_px,
	input  logic                              bar_fin,
	output logic                              valid_s7,
	output date_t                             date_s7,
	output logic [N_PX-1:0][PRICE_WIDTH-1:0]  px_s7,
	output logic                              fin_s7,
	output logic [KEY_W-1:0]                  key_s7
);

	localparam int YADJ_W      = 15;
	localparam int ERA_W       = 6;
	localparam int YOE_W       = 9;
	localparam int DD_W        = 9;
	localparam int DOE_W       = 18;
	localparam int WQ_W        = 20;
	localparam int ERA_RECIP_W = 13;
	localparam int CENT_RCP_W  = 6;
	localparam int WEEK_RCP_W  = 24;
	localparam int ERA_PROD_W  = YADJ_W + ERA_RECIP_W;
	localparam int CENT_PROD_W = YOE_W + CENT_RCP_W;
	localparam int WEEK_PROD_W = KEY_W + WEEK_RCP_W;

	localparam int ERA_YEARS       = 400;
	localparam int ERA_DAYS        = 146097;
	localparam int YEAR_DAYS       = 365;
	localparam int ERA_RECIP       = 5243;
	localparam int ERA_SH          = 21;
	localparam int CENT_RECIP      = 41;
	localparam int CENT_SH         = 12;
	localparam int WEEK_DAYS       = 7;
	localparam int WEEK_RECIP      = 9586981;
	localparam int WEEK_SH         = 26;
	localparam int MONDAY_BACK     = 2;
	localparam int MONTH_KEY_SCALE = 100;
	localparam logic [MONTH_W-1:0] LAST_SHIFTED_MONTH = 4'd2;

	typedef struct packed {
		date_t                             date;
		logic [N_PX-1:0][PRICE_WIDTH-1:0]  px;
		logic                              fin;
	} carry_t;

	function automatic logic [DD_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [DD_W-1:0] r;
		case (m) inside
			4'd0, 4'd12: r = 9'd275;
			4'd1, 4'd13: r = 9'd306;
			4'd2, 4'd14: r = 9'd337;
			4'd3:        r = 9'd0;
			4'd4:        r = 9'd31;
			4'd5:        r = 9'd61;
			4'd6:        r = 9'd92;
			4'd7:        r = 9'd122;
			4'd8:        r = 9'd153;
			4'd9:        r = 9'd184;
			4'd10:       r = 9'd214;
			4'd11:       r = 9'd245;
			default:     r = 9'd367;
		endcase
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7;

	logic [YADJ_W-1:0] y_s2;
	logic [ERA_W-1:0]  era_s2;
	logic [DD_W-1:0]   dd_s2, dd_s3;
	logic [YOE_W-1:0]  yoe_s3;
	logic [KEY_W-1:0]  era_days_s3, era_days_s4;
	logic [DOE_W-1:0]  doe1_s4;
	logic [KEY_W-1:0]  x_s5;
	logic [WQ_W-1:0]   q_s6;

	logic [YADJ_W-1:0]      y_adj;
	logic [ERA_PROD_W-1:0]  era_prod;
	logic [DD_W-1:0]        dd;
	logic [YADJ_W-1:0]      yoe_full;
	logic [KEY_W-1:0]       era_days;
	logic [CENT_PROD_W-1:0] cent_prod;
	logic [DOE_W-1:0]       doe1;
	logic [KEY_W-1:0]       x;
	logic [WEEK_PROD_W-1:0] week_prod;
	logic [KEY_W-1:0]       wkey, mkey, key;

	always_comb begin
		y_adj    = YADJ_W'(c_s1.date.year) + YADJ_W'(ERA_YEARS)
			- YADJ_W'(c_s1.date.month <= LAST_SHIFTED_MONTH);
		era_prod = ERA_PROD_W'(y_adj) * ERA_PROD_W'(ERA_RECIP);
		dd       = month_offset(c_s1.date.month) + DD_W'(c_s1.date.day);
	end

	always_comb begin
		yoe_full = y_s2 - YADJ_W'(era_s2) * YADJ_W'(ERA_YEARS);
		era_days = KEY_W'(era_s2) * KEY_W'(ERA_DAYS);
	end

	always_comb begin
		cent_prod = CENT_PROD_W'(yoe_s3) * CENT_PROD_W'(CENT_RECIP);
		doe1      = DOE_W'(yoe_s3) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe_s3[YOE_W-1:2])
			- DOE_W'(cent_prod[CENT_PROD_W-1:CENT_SH]) + DOE_W'(dd_s3);
	end

	assign x = era_days_s4 + KEY_W'(doe1_s4) + KEY_W'(1);

	assign week_prod = WEEK_PROD_W'(x_s5) * WEEK_PROD_W'(WEEK_RECIP);

	always_comb begin
		wkey = KEY_W'(q_s6) * KEY_W'(WEEK_DAYS) - KEY_W'(MONDAY_BACK);
		mkey = KEY_W'(c_s6.date.year) * KEY_W'(MONTH_KEY_SCALE) + KEY_W'(c_s6.date.month);
		key  = (mode == MODE_WEEKLY) ? wkey : mkey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= bar_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1        <= '{date: bar_date, px: bar_px, fin: bar_fin};
			c_s2        <= c_s1;
			c_s3        <= c_s2;
			c_s4        <= c_s3;
			c_s5        <= c_s4;
			c_s6        <= c_s5;
			c_s7        <= c_s6;
			y_s2        <= y_adj;
			era_s2      <= era_prod[ERA_SH +: ERA_W];
			dd_s2       <= dd;
			dd_s3       <= dd_s2;
			yoe_s3      <= yoe_full[YOE_W-1:0];
			era_days_s3 <= era_days;
			era_days_s4 <= era_days_s3;
			doe1_s4     <= doe1;
			x_s5        <= x;
			q_s6        <= week_prod[WEEK_SH +: WQ_W];
			key_s7      <= key;
		end
	end

	assign valid_s7 = v_s7;
	assign date_s7  = c_s7.date;
	assign px_s7    = c_s7.px;
	assign fin_s7   = c_s7.fin;

endmodule

// ===== src/opba_merge.sv =====
module opba_merge
	import opba_pkg::*;
#(
	parameter int PRICE_WIDTH = PRICE_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [MODE_W-1:0]                 mode,
	input  date_t                             date,
	input  logic [N_PX-1:0][PRICE_WIDTH-1:0]  px,
	input  logic                              fin,
	input  logic [KEY_W-1:0]                  key,
	output logic [PUSH_W-1:0]                 push_n,
	output date_t                             a_date,
	output logic [N_PX-1:0][PRICE_WIDTH-1:0]  a_px,
	output logic                              a_end,
	output date_t                             b_date,
	output logic [N_PX-1:0][PRICE_WIDTH-1:0]  b_px,
	output logic                              b_end,
	output logic                              grp_open
);

	logic                              open_q;
	logic [KEY_W-1:0]                  key_q;
	date_t                             date_q;
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  gpx_q;

	logic                              pass, close, merged;
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  gpx_n;
	logic [PUSH_W-1:0]                 n;

	always_comb begin
		pass   = (mode != MODE_WEEKLY) && (mode != MODE_MONTHLY);
		close  = open_q && (key != key_q);
		merged = open_q && !close;

		gpx_n[PX_OPEN]  = merged ? gpx_q[PX_OPEN] : px[PX_OPEN];
		gpx_n[PX_HIGH]  = (merged && (gpx_q[PX_HIGH] >= px[PX_HIGH])) ? gpx_q[PX_HIGH]
			: px[PX_HIGH];
		gpx_n[PX_LOW]   = (merged && (gpx_q[PX_LOW] <= px[PX_LOW])) ? gpx_q[PX_LOW]
			: px[PX_LOW];
		gpx_n[PX_CLOSE] = px[PX_CLOSE];
	end

	always_comb begin
		a_date = date_q;
		a_px   = gpx_q;
		b_date = date;
		b_px   = px;
		n      = PUSH_W'(0);
		if (pass) begin
			if (open_q) begin
				n = PUSH_W'(2);
			end else begin
				n      = PUSH_W'(1);
				a_date = date;
				a_px   = px;
			end
		end else if (close && fin) begin
			n    = PUSH_W'(2);
			b_px = gpx_n;
		end else if (close) begin
			n = PUSH_W'(1);
		end else if (fin) begin
			n      = PUSH_W'(1);
			a_date = date;
			a_px   = gpx_n;
		end
	end

	assign push_n   = fire ? n : PUSH_W'(0);
	assign a_end    = (n == PUSH_W'(1));
	assign b_end    = 1'b1;
	assign grp_open = open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (fire) begin
			open_q <= !pass && !fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			key_q  <= key;
			date_q <= date;
			gpx_q  <= gpx_n;
		end
	end

endmodule

// ===== src/opba_out_queue.sv =====
module opba_out_queue
	import opba_pkg::*;
#(
	parameter int PRICE_WIDTH = PRICE_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [PUSH_W-1:0]                 push_n,
	input  date_t                             a_date,
	input  logic [N_PX-1:0][PRICE_WIDTH-1:0]  a_px,
	input  logic                              a_end,
	input  date_t                             b_date,
	input  logic [N_PX-1:0][PRICE_WIDTH-1:0]  b_px,
	input  logic                              b_end,
	input  logic                              stall,
	output logic                              valid,
	output date_t                             head_date,
	output logic [N_PX-1:0][PRICE_WIDTH-1:0]  head_px,
	output logic                              head_end,
	output q_stat_t                           stat
);

	date_t                             date_q [QUEUE_DEPTH];
	logic [N_PX-1:0][PRICE_WIDTH-1:0]  px_q   [QUEUE_DEPTH];
	logic                              end_q  [QUEUE_DEPTH];

	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_b;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign valid    = (count_q != QCNT_W'(0));
	assign pop      = valid && !stall;
	assign wr_ptr_b = wr_ptr_q + QPTR_W'(1);

	assign head_date = date_q[rd_ptr_q];
	assign head_px   = px_q[rd_ptr_q];
	assign head_end  = end_q[rd_ptr_q];

	assign stat.count = count_q;
	assign stat.room  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != PUSH_W'(0)) begin
			date_q[wr_ptr_q] <= a_date;
			px_q[wr_ptr_q]   <= a_px;
			end_q[wr_ptr_q]  <= a_end;
		end
		if (push_n == PUSH_W'(2)) begin
			date_q[wr_ptr_b] <= b_date;
			px_q[wr_ptr_b]   <= b_px;
			end_q[wr_ptr_b]  <= b_end;
		end
	end

endmodule
